// ===== sv/tefp_pkg.sv =====
// tefp_pkg: shared types and constants of the timing entropy fast pool.
// Used by the top level and by its port checker; depends on nothing.
`default_nettype none

package tefp_pkg;

  localparam int POOLS_DEFAULT = 256;

  // mixing and stuck test constants
  localparam int ROT_LEFT = 7;
  localparam int TAG_SHIFT = 56;
  localparam logic [1:0] HISTORY_NEEDED = 2'd3;
  localparam logic [15:0] PASS_MAX = 16'hFFFF;

  // configuration registers
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 21;
  localparam logic [CFG_INDEX_W-1:0] REG_FOLD_THRESHOLD = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_SEED_THRESHOLD = 1'b1;
  localparam logic [15:0] FOLD_RESET = 16'd64;
  localparam logic [20:0] SEED_RESET = 21'd1024;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_DRAIN  = 1'b1
  } op_t;

  typedef struct packed {
    op_t         operation;
    logic [7:0]  core;
    logic [63:0] timestamp;
    logic [7:0]  source;
  } in_word_t;

  typedef struct packed {
    logic        stuck;
    logic [63:0] accumulator;
    logic [15:0] pass_count;
    logic        fold_due;
    logic        seeded;
  } out_word_t;

endpackage

`default_nettype wire

// ===== sv/timing_entropy_fast_pool.sv =====
// timing_entropy_fast_pool: per-core entropy pools with a stuck test on event timing.
// Depends on tefp_pkg for the word types, register indexes and constants.
`default_nettype none

// Takes one word per cycle while no clear runs and stage one can move on, and returns
// one result word per input word. An accepted word is held in stage one, and its result
// word is registered when it leaves stage one, which waits while a stalled output still
// holds a result. The pool table is one memory with one read and one write port: each
// word reads its pool when accepted and writes it back when it leaves stage one, with a
// bypass for a word that hits the pool just written. After reset the table is cleared
// one pool per cycle, with in_ready low; configuration writes are taken during that
// time. Cores at or above POOLS wrap modulo POOLS.
module timing_entropy_fast_pool #(
  parameter int POOLS = tefp_pkg::POOLS_DEFAULT
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  tefp_pkg::in_word_t                   in_word,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output tefp_pkg::out_word_t                  out_word,
  input  wire                                  cfg_write,
  input  wire  [tefp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire  [tefp_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import tefp_pkg::*;

  localparam int IDX_W = (POOLS > 1) ? $clog2(POOLS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOLS - 1);

  typedef struct packed {
    logic [63:0] acc;
    logic [63:0] last_time;
    logic [63:0] prev_delta;
    logic [63:0] last_second_delta;
    logic [15:0] passes;
    logic [1:0]  history;
  } pool_entry_t;

  // core to pool index, modulo POOLS
  logic [IDX_W-1:0] pool_map [256];
  for (genvar g = 0; g < 256; g++) begin : g_map
    assign pool_map[g] = IDX_W'(g % POOLS);
  end

  pool_entry_t pool_mem [POOLS];

  logic [15:0]      fold_thr;
  logic [20:0]      seed_thr;
  logic             clr_busy;
  logic [IDX_W-1:0] clr_idx;
  logic             s1_valid;
  in_word_t         s1_word;
  logic [IDX_W-1:0] s1_idx;
  logic             byp_hit;
  pool_entry_t      byp_entry;
  pool_entry_t      rd_entry;
  logic [31:0]      drained_total;
  logic             seeded_flag;

  logic             in_fire;
  logic             s1_fire;
  logic [IDX_W-1:0] in_idx;
  pool_entry_t      ent;
  pool_entry_t      wr_entry;
  logic [63:0]      mixed;
  logic [63:0]      d1;
  logic [63:0]      d2;
  logic [63:0]      d3;
  logic             fail;
  logic [15:0]      passes_next;
  logic [32:0]      total_sum;
  logic [31:0]      drained_total_next;
  logic             seeded_flag_next;
  out_word_t        out_word_next;

  assign in_idx   = pool_map[in_word.core];
  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !clr_busy && (!s1_valid || s1_fire);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    ent   = byp_hit ? byp_entry : rd_entry;
    mixed = {ent.acc[63-ROT_LEFT:0], ent.acc[63:64-ROT_LEFT]} ^ s1_word.timestamp
            ^ (64'(s1_word.source) << TAG_SHIFT);
    d1    = s1_word.timestamp - ent.last_time;
    d2    = s1_word.timestamp - ent.last_time - ent.prev_delta;
    d3    = s1_word.timestamp - ent.last_time - ent.prev_delta - ent.last_second_delta;
    fail  = (ent.history < HISTORY_NEEDED) || (d1 == '0) || (d2 == '0) || (d3 == '0);
    passes_next = (!fail && ent.passes != PASS_MAX) ? ent.passes + 16'd1 : ent.passes;

    total_sum = {1'b0, drained_total} + {17'b0, ent.passes};
    drained_total_next = drained_total;
    seeded_flag_next   = seeded_flag;
    wr_entry           = ent;
    out_word_next      = '0;

    if (s1_word.operation == OP_DRAIN) begin
      wr_entry.passes = '0;
      if (ent.passes != '0) begin
        drained_total_next = total_sum[32] ? '1 : total_sum[31:0];
        if (drained_total_next >= {11'b0, seed_thr}) begin
          seeded_flag_next = 1'b1;
        end
      end
      out_word_next.stuck       = 1'b0;
      out_word_next.accumulator = ent.acc;
      out_word_next.pass_count  = ent.passes;
    end else begin
      wr_entry.acc               = mixed;
      wr_entry.last_time         = s1_word.timestamp;
      wr_entry.prev_delta        = d1;
      wr_entry.last_second_delta = d2;
      wr_entry.passes            = passes_next;
      wr_entry.history = (ent.history < HISTORY_NEEDED) ? ent.history + 2'd1 : ent.history;
      out_word_next.stuck        = fail;
      out_word_next.accumulator  = mixed;
      out_word_next.pass_count   = passes_next;
    end
    out_word_next.fold_due = out_word_next.pass_count >= fold_thr;
    out_word_next.seeded   = seeded_flag_next;
  end

  // pool table: read on accept, write back or clear
  always_ff @(posedge clk) begin
    if (clr_busy) begin
      pool_mem[clr_idx] <= '0;
    end else if (s1_fire) begin
      pool_mem[s1_idx] <= wr_entry;
    end
    if (in_fire) begin
      rd_entry <= pool_mem[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_idx  <= '0;
    end else if (clr_busy) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == LAST_IDX) begin
        clr_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fold_thr <= FOLD_RESET;
      seed_thr <= SEED_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FOLD_THRESHOLD: fold_thr <= cfg_data[15:0];
        REG_SEED_THRESHOLD: seed_thr <= cfg_data[20:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      byp_hit       <= 1'b0;
      out_valid     <= 1'b0;
      drained_total <= '0;
      seeded_flag   <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
        // the pool read now misses the write of the word leaving stage one
        byp_hit  <= s1_fire && (s1_idx == in_idx);
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        out_valid     <= 1'b1;
        drained_total <= drained_total_next;
        seeded_flag   <= seeded_flag_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_word <= in_word;
      s1_idx  <= in_idx;
    end
    if (s1_fire) begin
      byp_entry <= wr_entry;
      out_word  <= out_word_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/tefp_checker.sv =====
// tefp_checker: port-level assertions for timing_entropy_fast_pool, bound to the top.
// Depends on tefp_pkg for the word types and register indexes.
`default_nettype none

module tefp_checker (
  input wire                                clk,
  input wire                                rst,
  input wire                                in_valid,
  input wire                                in_ready,
  input wire                                out_valid,
  input wire                                out_ready,
  input tefp_pkg::out_word_t                out_word,
  input wire                                cfg_write,
  input wire [tefp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input wire [tefp_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import tefp_pkg::*;

  logic       in_fire;
  logic       out_fire;
  logic [1:0] pending;
  logic       seen_seeded;
  logic [15:0] fold_shadow;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending     <= '0;
      seen_seeded <= 1'b0;
      fold_shadow <= FOLD_RESET;
    end else begin
      pending <= pending + {1'b0, in_fire} - {1'b0, out_fire};
      if (out_fire && out_word.seeded) begin
        seen_seeded <= 1'b1;
      end
      if (cfg_write && cfg_index == REG_FOLD_THRESHOLD) begin
        fold_shadow <= cfg_data[15:0];
      end
    end
  end

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // no result word without an accepted input word
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0)
    else $error("result word without input word");

  // seeded is sticky until reset
  a_seeded_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && seen_seeded |-> out_word.seeded)
    else $error("seeded flag dropped");

  // fold due follows the written threshold
  a_fold_due: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_word.fold_due == (out_word.pass_count >= fold_shadow))
    else $error("fold_due disagrees with threshold");

  // the table clear after reset blocks input
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input taken during table clear");

endmodule

bind timing_entropy_fast_pool tefp_checker u_tefp_checker (.*);

`default_nettype wire

// ===== sim/tb_timing_entropy_fast_pool.sv =====
// tb_timing_entropy_fast_pool: self-checking bench for the per-core entropy pools.
// Predicts every result word from its own copy of the pool table; needs tefp_pkg
// and timing_entropy_fast_pool.
module tb_timing_entropy_fast_pool;
  import tefp_pkg::*;

  localparam int POOL_COUNT = POOLS_DEFAULT;
  localparam int STALL_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_word;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  timing_entropy_fast_pool i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word(out_word),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predicted pool table and registers
  logic [63:0] mix_acc [POOL_COUNT];
  logic [63:0] last_stamp [POOL_COUNT];
  logic [63:0] last_gap [POOL_COUNT];
  logic [63:0] last_gap_change [POOL_COUNT];
  logic [15:0] pass_tally [POOL_COUNT];
  logic [1:0] history_len [POOL_COUNT];
  logic [31:0] drained_sum;
  logic seeded_now;
  logic [15:0] fold_level;
  logic [20:0] seed_level;

  out_word_t pool_reports[$];
  out_word_t report_due;
  int idle_pct = 8;
  int hold_request = 0;
  int hold_left = 0;
  int error_count = 0;
  int words_sent = 0;
  int results_checked = 0;
  int stall_cycles = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic out_word_t pool_update(input in_word_t w);
    out_word_t r;
    int unsigned p;
    logic [63:0] a, d1, d2, d3;
    logic [15:0] cnt;
    logic fail;
    p = w.core % POOL_COUNT;
    r = '0;
    if (w.operation == OP_SAMPLE) begin
      a = {mix_acc[p][63-ROT_LEFT:0], mix_acc[p][63:64-ROT_LEFT]} ^ w.timestamp
          ^ {w.source, 56'd0};
      mix_acc[p] = a;
      d1 = w.timestamp - last_stamp[p];
      d2 = d1 - last_gap[p];
      d3 = d2 - last_gap_change[p];
      fail = (history_len[p] < HISTORY_NEEDED) || d1 == 0 || d2 == 0 || d3 == 0;
      last_stamp[p] = w.timestamp;
      last_gap[p] = d1;
      last_gap_change[p] = d2;
      if (history_len[p] < HISTORY_NEEDED) history_len[p] = history_len[p] + 2'd1;
      if (!fail && pass_tally[p] != PASS_MAX) pass_tally[p] = pass_tally[p] + 16'd1;
      r.stuck = fail;
      r.accumulator = a;
      cnt = pass_tally[p];
    end else begin
      r.accumulator = mix_acc[p];
      cnt = pass_tally[p];
      pass_tally[p] = '0;
      if (cnt != 0) begin
        if (drained_sum > 32'hFFFF_FFFF - {16'd0, cnt}) drained_sum = 32'hFFFF_FFFF;
        else drained_sum = drained_sum + {16'd0, cnt};
        if (drained_sum >= {11'd0, seed_level}) seeded_now = 1'b1;
      end
    end
    r.pass_count = cnt;
    r.fold_due = (cnt >= fold_level);
    r.seeded = seeded_now;
    return r;
  endfunction

  // next timestamp for a pool that clears all three delta checks
  function automatic logic [63:0] passing_time(input logic [7:0] core);
    logic [63:0] t, d1, d2;
    do begin
      if ($urandom_range(3) == 0) t = last_stamp[core] + {$urandom, $urandom};
      else t = last_stamp[core] + 64'($urandom_range(1, 5000));
      d1 = t - last_stamp[core];
      d2 = d1 - last_gap[core];
    end while (d1 == 0 || d2 == 0 || d2 == last_gap_change[core]);
    return t;
  endfunction

  task automatic send_word(input in_word_t w);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
    pool_reports.push_back(pool_update(w));
    words_sent++;
  endtask

  task automatic send_sample(input logic [7:0] core, input logic [63:0] ts,
                             input logic [7:0] src);
    in_word_t w;
    w.operation = OP_SAMPLE;
    w.core = core;
    w.timestamp = ts;
    w.source = src;
    send_word(w);
  endtask

  // timestamp and source of a drain are ignored, so they carry noise
  task automatic send_drain(input logic [7:0] core);
    in_word_t w;
    w.operation = OP_DRAIN;
    w.core = core;
    w.timestamp = {$urandom, $urandom};
    w.source = 8'($urandom_range(255));
    send_word(w);
  endtask

  // drop valid and wait for the pipeline to empty
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pool_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_FOLD_THRESHOLD) fold_level = value[15:0];
    else if (idx == REG_SEED_THRESHOLD) seed_level = value[20:0];
  endtask

  task automatic test_directed();
    // reset thresholds still in force
    send_drain(8'd0);
    settle();
    write_reg(REG_FOLD_THRESHOLD, 1);
    write_reg(REG_SEED_THRESHOLD, 1048576);
    // short history, then a pass, a repeated stamp and a constant gap
    send_sample(8'd3, 64'd100, 8'h00);
    send_sample(8'd3, 64'd101, 8'h80);
    send_sample(8'd3, 64'd103, 8'h01);
    send_sample(8'd3, 64'd107, 8'h7F);
    send_sample(8'd3, 64'd107, 8'hAA);
    send_sample(8'd3, 64'd108, 8'h55);
    send_sample(8'd3, 64'd109, 8'hFF);
    // constant second difference trips only the third delta check
    send_sample(8'd4, 64'd200, 8'h10);
    send_sample(8'd4, 64'd201, 8'h20);
    send_sample(8'd4, 64'd203, 8'h40);
    send_sample(8'd4, 64'd206, 8'h08);
    send_sample(8'd4, 64'd210, 8'h04);
    // timestamp and source extremes, top pool, stamp wrapping to zero
    send_sample(8'd255, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
    send_sample(8'd255, 64'd0, 8'h00);
    send_drain(8'd3);
    send_drain(8'd3);
    send_drain(8'd255);
    send_drain(8'd4);
  endtask

  task automatic test_backpressure();
    logic [7:0] core;
    settle();
    write_reg(REG_FOLD_THRESHOLD, 64);
    write_reg(REG_SEED_THRESHOLD, 1048575);
    hold_request = 300;
    for (int i = 0; i < 40; i++) begin
      core = 8'($urandom_range(3));
      if (i % 10 == 9) send_drain(core);
      else send_sample(core, passing_time(core), 8'($urandom_range(255)));
    end
  endtask

  task automatic test_random(input int count, input int unsigned fold,
                             input int unsigned seed);
    logic [7:0] core;
    logic [63:0] ts;
    int pick;
    settle();
    write_reg(REG_FOLD_THRESHOLD, fold);
    write_reg(REG_SEED_THRESHOLD, seed);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) core = 8'($urandom_range(255));
      else core = 8'($urandom_range(3));
      pick = $urandom_range(99);
      if (pick < 12) begin
        send_drain(core);
      end else begin
        if (pick < 62) ts = passing_time(core);
        else if (pick < 68) ts = last_stamp[core];
        else if (pick < 74) ts = last_stamp[core] + last_gap[core];
        else if (pick < 80) ts = last_stamp[core] + last_gap[core] + last_gap_change[core];
        else ts = {$urandom, $urandom};
        send_sample(core, ts, 8'($urandom_range(255)));
      end
    end
  endtask

  task automatic test_zero_thresholds();
    settle();
    write_reg(REG_FOLD_THRESHOLD, 0);
    write_reg(REG_SEED_THRESHOLD, 0);
    send_drain(8'd12);
    send_drain(8'd12);
    repeat (6) send_sample(8'd12, passing_time(8'd12), 8'($urandom_range(255)));
    send_drain(8'd12);
  endtask

  // back to back words with neither side idling
  task automatic test_burst(input int count);
    logic [7:0] core;
    settle();
    idle_pct = 0;
    for (int i = 0; i < count; i++) begin
      core = 8'($urandom_range(7));
      if (i % 16 == 15) send_drain(core);
      else send_sample(core, passing_time(core), 8'($urandom_range(255)));
    end
    idle_pct = 8;
  endtask

  // receiver: random stalls plus a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pool_reports.size() == 0) begin
        $error("result word with nothing expected");
        error_count++;
      end else begin
        report_due = pool_reports.pop_front();
        check_field("stuck", report_due.stuck, out_word.stuck);
        check_field("accumulator", report_due.accumulator, out_word.accumulator);
        check_field("pass_count", report_due.pass_count, out_word.pass_count);
        check_field("fold_due", report_due.fold_due, out_word.fold_due);
        check_field("seeded", report_due.seeded, out_word.seeded);
        results_checked++;
      end
    end
  end

  // covers the clearing pass after reset and the long receiver hold-off
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < POOL_COUNT; i++) begin
      mix_acc[i] = '0;
      last_stamp[i] = '0;
      last_gap[i] = '0;
      last_gap_change[i] = '0;
      pass_tally[i] = '0;
      history_len[i] = '0;
    end
    drained_sum = '0;
    seeded_now = 1'b0;
    fold_level = FOLD_RESET;
    seed_level = SEED_RESET;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_backpressure();
    test_random(220, 3, 1048576);
    test_zero_thresholds();
    test_burst(100);
    test_random(220, 1, 1);

    settle();
    repeat (8) @(posedge clk);
    $display("%0d words sent, %0d results checked", words_sent, results_checked);
    $display("covered stuck test cases, drains, stalls, gap-free bursts, threshold extremes");
    if (error_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
